### rtl/page_walk_range_attribute_check_unit_defines.svh
// ----------------------------------------------------------------------------
// Page walk range attribute check: assertion macros
// Shared concurrent assertion helpers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PAGE_WALK_RANGE_ATTRIBUTE_CHECK_UNIT_DEFINES_SVH
`define PAGE_WALK_RANGE_ATTRIBUTE_CHECK_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PWRAC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PWRAC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define PWRAC_ASSERT_IMP(lbl, ante, cons, msg)
`define PWRAC_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/pwrac_pkg.sv
// ----------------------------------------------------------------------------
// Page walk range attribute check: package
// Types, codes, masks and address helpers shared by the walker files.
// ----------------------------------------------------------------------------
package pwrac_pkg;

	localparam int DATA_W            = 64;
	localparam int PA_W              = 52;
	localparam int PHYS_ADDR_BITS_DEF = 52;
	localparam int CFG_IDX_W         = 1;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ROOT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIVE_LEVEL = 1'd1;

	// item function codes
	localparam logic FUNC_QUERY = 1'b0;
	localparam logic FUNC_ENTRY = 1'b1;

	// result status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_BAD_LEN  = 2'd1;
	localparam logic [1:0] STAT_UNSUP    = 2'd2;
	localparam logic [1:0] STAT_MISMATCH = 2'd3;

	// walk levels
	localparam logic [2:0] LVL_PT   = 3'd1;
	localparam logic [2:0] LVL_PD   = 3'd2;
	localparam logic [2:0] LVL_PDPT = 3'd3;
	localparam logic [2:0] LVL_PML4 = 3'd4;
	localparam logic [2:0] LVL_PML5 = 3'd5;

	localparam logic [63:0] MASK_4K = 64'h000F_FFFF_FFFF_F000;
	localparam logic [63:0] MASK_2M = 64'h000F_FFFF_FFE0_0000;
	localparam logic [63:0] MASK_1G = 64'h000F_FFFF_C000_0000;

	localparam int PG_W = 31;
	localparam logic [PG_W-1:0] PAGE_4K = 31'h0000_1000;
	localparam logic [PG_W-1:0] PAGE_2M = 31'h0020_0000;
	localparam logic [PG_W-1:0] PAGE_1G = 31'h4000_0000;

	localparam int BIT_P  = 0;
	localparam int BIT_RW = 1;
	localparam int BIT_US = 2;
	localparam int BIT_PS = 7;
	localparam int BIT_NX = 63;

	typedef enum logic [2:0] {
		S_IDLE,
		S_OFFS,
		S_STEP,
		S_REM,
		S_ADV,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic              func;
		logic [DATA_W-1:0] start_address;
		logic [DATA_W-1:0] range_length;
		logic [DATA_W-1:0] entry_word;
	} item_t;

	typedef struct packed {
		logic [PA_W-1:0] table_root_address;
		logic            five_level_enable;
	} cfg_t;

	typedef struct packed {
		logic            read_request;
		logic [PA_W-1:0] read_address;
		logic            done_res;
		logic [1:0]      status;
		logic [3:0]      attributes;
	} res_t;

	// leaf flags: not present, read only, no execute, supervisor
	function automatic logic [3:0] leaf_attrs(logic [DATA_W-1:0] e);
		return {~e[BIT_US], e[BIT_NX], ~e[BIT_RW], ~e[BIT_P]};
	endfunction

	// table base | index*8 for the given level
	function automatic logic [PA_W-1:0] entry_addr(logic [DATA_W-1:0] base,
			logic [2:0] level, logic [DATA_W-1:0] addr, logic [DATA_W-1:0] phys_mask);
		logic [8:0]        idx;
		logic [DATA_W-1:0] full;
		unique case (level)
			LVL_PT:   idx = addr[20:12];
			LVL_PD:   idx = addr[29:21];
			LVL_PDPT: idx = addr[38:30];
			LVL_PML4: idx = addr[47:39];
			LVL_PML5: idx = addr[56:48];
			default:  idx = '0;
		endcase
		full = (base & MASK_4K & phys_mask) | {52'd0, idx, 3'd0};
		return full[PA_W-1:0];
	endfunction

endpackage

### rtl/pwrac_query_if.sv
// ----------------------------------------------------------------------------
// Page walk range attribute check: query channel
// Valid/ready channel carrying range queries and entry read responses.
// ----------------------------------------------------------------------------
interface pwrac_query_if import pwrac_pkg::*; ();

	logic              valid;
	logic              ready;
	logic              func;
	logic [DATA_W-1:0] start_address;
	logic [DATA_W-1:0] range_length;
	logic [DATA_W-1:0] entry_word;

	modport source (output valid, func, start_address, range_length, entry_word,
		input ready);
	modport sink (input valid, func, start_address, range_length, entry_word,
		output ready);

endinterface

### rtl/pwrac_result_if.sv
// ----------------------------------------------------------------------------
// Page walk range attribute check: result channel
// Valid/ready channel carrying entry read requests and final answers.
// ----------------------------------------------------------------------------
interface pwrac_result_if import pwrac_pkg::*; ();

	logic            valid;
	logic            ready;
	logic            read_request;
	logic [PA_W-1:0] read_address;
	logic            done_res;
	logic [1:0]      status;
	logic [3:0]      attributes;

	modport source (output valid, read_request, read_address, done_res, status,
		attributes, input ready);
	modport sink (input valid, read_request, read_address, done_res, status,
		attributes, output ready);

endinterface

### rtl/pwrac_alu.sv
// ----------------------------------------------------------------------------
// Page walk range attribute check: shared adder
// One 64-bit add/subtract unit reused by every step of the leaf advance.
// ----------------------------------------------------------------------------
module pwrac_alu import pwrac_pkg::*; (
	input  logic [DATA_W-1:0] a,
	input  logic [DATA_W-1:0] b,
	input  logic              sub,
	output logic [DATA_W-1:0] y
);

	// a + b, or a - b as a + ~b + 1
	assign y = a + (b ^ {DATA_W{sub}}) + DATA_W'(sub);

endmodule

### rtl/pwrac_seq.sv
// ----------------------------------------------------------------------------
// Page walk range attribute check: walk sequencer
// Holds the walk state, decodes entries and steps the shared adder through
// the leaf advance (offset, step, remaining size, next address).
// ----------------------------------------------------------------------------
`include "page_walk_range_attribute_check_unit_defines.svh"

module pwrac_seq import pwrac_pkg::*; #(
	parameter int PHYS_ADDR_BITS = PHYS_ADDR_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  item_t item,
	input  logic  acc,
	output logic  idle,
	output logic  res_load,
	output res_t  res
);

	localparam logic [DATA_W-1:0] PHYS_MASK = (64'd1 << PHYS_ADDR_BITS) - 64'd1;

	state_t            state_q, state_d;
	logic              busy_q, busy_d;
	logic [2:0]        level_q, level_d;
	logic [DATA_W-1:0] cur_q, cur_d;
	logic [DATA_W-1:0] rem_q, rem_d;
	logic [DATA_W-1:0] frame_q, frame_d;
	logic [DATA_W-1:0] tmp_q, tmp_d;
	logic [PG_W-1:0]   size_q, size_d;
	logic [3:0]        prev_attr_q, prev_attr_d;
	logic              prev_valid_q, prev_valid_d;
	logic [3:0]        last_attr_q, last_attr_d;

	logic [DATA_W-1:0] alu_a, alu_b, alu_y;
	logic              alu_sub;

	logic [DATA_W-1:0] root64;
	logic [2:0]        top_lvl;
	logic [3:0]        ent_attr;
	logic              lvl_known, unsup, is_leaf, mismatch, leaf_start, entry_acc;

	pwrac_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.y   (alu_y)
	);

	// entry decode
	assign root64    = {12'd0, cfg.table_root_address};
	assign top_lvl   = cfg.five_level_enable ? LVL_PML5 : LVL_PML4;
	assign ent_attr  = leaf_attrs(item.entry_word);
	assign lvl_known = (level_q == LVL_PT) || (level_q == LVL_PD) || (level_q == LVL_PDPT)
		|| (level_q == LVL_PML4) || (level_q == LVL_PML5);
	assign unsup     = !lvl_known || ((item.entry_word == '0)
		&& !((level_q == LVL_PT) && (cur_q == '0)));
	assign is_leaf   = (level_q == LVL_PT) || (((level_q == LVL_PD) || (level_q == LVL_PDPT))
		&& item.entry_word[BIT_PS]);
	assign mismatch  = prev_valid_q && (ent_attr != prev_attr_q);
	assign entry_acc = acc && (item.func == FUNC_ENTRY) && busy_q;
	assign leaf_start = entry_acc && !unsup && is_leaf && !mismatch;
	assign idle      = (state_q == S_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (leaf_start) state_d = S_OFFS;
			S_OFFS: state_d = S_STEP;
			S_STEP: state_d = S_REM;
			S_REM:  state_d = S_ADV;
			S_ADV:  state_d = S_EMIT;
			S_EMIT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// datapath and results
	always_comb begin
		busy_d       = busy_q;
		level_d      = level_q;
		cur_d        = cur_q;
		rem_d        = rem_q;
		frame_d      = frame_q;
		tmp_d        = tmp_q;
		size_d       = size_q;
		prev_attr_d  = prev_attr_q;
		prev_valid_d = prev_valid_q;
		last_attr_d  = last_attr_q;
		alu_a        = cur_q;
		alu_b        = tmp_q;
		alu_sub      = 1'b0;
		res          = '0;
		res_load     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (acc && (item.func == FUNC_QUERY)) begin
					prev_valid_d = 1'b0;
					prev_attr_d  = '0;
					last_attr_d  = '0;
					res_load     = 1'b1;
					if ((item.range_length[63:12] == '0) || item.range_length[63]) begin
						busy_d       = 1'b0;
						res.done_res = 1'b1;
						res.status   = STAT_BAD_LEN;
					end else begin
						busy_d           = 1'b1;
						cur_d            = item.start_address;
						rem_d            = item.range_length;
						level_d          = top_lvl;
						res.read_request = 1'b1;
						res.read_address = entry_addr(root64, top_lvl, item.start_address,
							PHYS_MASK);
					end
				end else if (entry_acc) begin
					if (unsup) begin
						busy_d         = 1'b0;
						res_load       = 1'b1;
						res.done_res   = 1'b1;
						res.status     = STAT_UNSUP;
						res.attributes = last_attr_q;
					end else if (is_leaf) begin
						last_attr_d = ent_attr;
						if (mismatch) begin
							busy_d         = 1'b0;
							res_load       = 1'b1;
							res.done_res   = 1'b1;
							res.status     = STAT_MISMATCH;
							res.attributes = ent_attr;
						end else begin
							prev_attr_d  = ent_attr;
							prev_valid_d = 1'b1;
							priority if (level_q == LVL_PDPT) begin
								frame_d = item.entry_word & MASK_1G & PHYS_MASK;
								size_d  = PAGE_1G;
							end else if (level_q == LVL_PD) begin
								frame_d = item.entry_word & MASK_2M & PHYS_MASK;
								size_d  = PAGE_2M;
							end else begin
								frame_d = item.entry_word & MASK_4K & PHYS_MASK;
								size_d  = PAGE_4K;
							end
						end
					end else begin
						level_d          = level_q - 3'd1;
						res_load         = 1'b1;
						res.read_request = 1'b1;
						res.read_address = entry_addr(item.entry_word, level_q - 3'd1, cur_q,
							PHYS_MASK);
					end
				end
			end
			// offset = address - frame
			S_OFFS: begin
				alu_a   = cur_q;
				alu_b   = frame_q;
				alu_sub = 1'b1;
				tmp_d   = alu_y;
			end
			// step = page size - offset
			S_STEP: begin
				alu_a   = {{(DATA_W-PG_W){1'b0}}, size_q};
				alu_b   = tmp_q;
				alu_sub = 1'b1;
				tmp_d   = alu_y;
			end
			S_REM: begin
				alu_a   = rem_q;
				alu_b   = tmp_q;
				alu_sub = 1'b1;
				rem_d   = alu_y;
			end
			S_ADV: begin
				alu_a   = cur_q;
				alu_b   = tmp_q;
				alu_sub = 1'b0;
				cur_d   = alu_y;
			end
			// restart from the top while remaining size is positive
			S_EMIT: begin
				res_load = 1'b1;
				if ((rem_q != '0) && !rem_q[63]) begin
					level_d          = top_lvl;
					res.read_request = 1'b1;
					res.read_address = entry_addr(root64, top_lvl, cur_q, PHYS_MASK);
				end else begin
					busy_d         = 1'b0;
					res.done_res   = 1'b1;
					res.status     = STAT_OK;
					res.attributes = last_attr_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			busy_q       <= 1'b0;
			level_q      <= '0;
			cur_q        <= '0;
			rem_q        <= '0;
			frame_q      <= '0;
			tmp_q        <= '0;
			size_q       <= '0;
			prev_attr_q  <= '0;
			prev_valid_q <= 1'b0;
			last_attr_q  <= '0;
		end else begin
			state_q      <= state_d;
			busy_q       <= busy_d;
			level_q      <= level_d;
			cur_q        <= cur_d;
			rem_q        <= rem_d;
			frame_q      <= frame_d;
			tmp_q        <= tmp_d;
			size_q       <= size_d;
			prev_attr_q  <= prev_attr_d;
			prev_valid_q <= prev_valid_d;
			last_attr_q  <= last_attr_d;
		end
	end

	`PWRAC_ASSERT_IMP(a_load_src, res_load, (idle && acc) || (state_q == S_EMIT), "result loaded outside accept or emit")
	`PWRAC_ASSERT_IMP(a_one_kind, res_load, res.read_request != res.done_res, "result is neither or both of request and answer")
	`PWRAC_ASSERT_IMP(a_walk_busy, state_q != S_IDLE, busy_q, "advance running with no walk in progress")
	`PWRAC_ASSERT_NXT(a_offs_next, state_q == S_OFFS, state_q == S_STEP, "advance sequence skipped a step")

endmodule

### rtl/page_walk_range_attribute_check_unit.sv
// ----------------------------------------------------------------------------
// Page walk range attribute check unit
// Checks that a byte range carries one attribute set by walking x86-64
// four- or five-level page tables, one entry fetch per step.
// ----------------------------------------------------------------------------
// Usage:
//   query  : func 0 starts a range check (start_address, range_length);
//            func 1 returns the 64-bit table entry asked for last.
//   result : either a read request (read_address of one 8-byte entry) or a
//            final answer (done_res, status, attributes).
//   config : cfg_we/cfg_index/cfg_wdata write the table root and the
//            five-level enable; write them only while no query is active.
// Timing: a query start or a non-leaf entry loads its result at the accept
//   edge, so it can be taken in the cycle after the item. A leaf entry runs
//   the shared adder four times (offset, step, remaining size, advance) and
//   loads its result in the emit state; query.ready is low meanwhile.
//   Sustained rate: one item per cycle for table steps while the output
//   register can drain; a leaf holds off new items until its emit state ends.
// A response arriving with no walk in progress is dropped without a result.
// Stall: one output register holds the result; query.ready stays low while
//   it is full and result.ready is low.
// Reset clears the walk, the output register and both config registers.
// ----------------------------------------------------------------------------
module page_walk_range_attribute_check_unit import pwrac_pkg::*; #(
	parameter int PHYS_ADDR_BITS = PHYS_ADDR_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	pwrac_query_if.sink          query,
	pwrac_result_if.source       result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PA_W-1:0]      cfg_wdata
);

	cfg_t  cfg_q;
	item_t item;
	res_t  res, res_q;
	logic  res_load, seq_idle, acc, ov_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TABLE_ROOT: cfg_q.table_root_address <= cfg_wdata;
				CFG_FIVE_LEVEL: cfg_q.five_level_enable  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// input side
	assign query.ready = seq_idle && (!ov_q || result.ready);
	assign acc         = query.valid && query.ready;

	assign item.func          = query.func;
	assign item.start_address = query.start_address;
	assign item.range_length  = query.range_length;
	assign item.entry_word    = query.entry_word;

	pwrac_seq #(
		.PHYS_ADDR_BITS (PHYS_ADDR_BITS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.item     (item),
		.acc      (acc),
		.idle     (seq_idle),
		.res_load (res_load),
		.res      (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			res_q <= '0;
		end else if (res_load) begin
			ov_q  <= 1'b1;
			res_q <= res;
		end else if (result.ready) begin
			ov_q  <= 1'b0;
		end
	end

	assign result.valid        = ov_q;
	assign result.read_request = res_q.read_request;
	assign result.read_address = res_q.read_address;
	assign result.done_res     = res_q.done_res;
	assign result.status       = res_q.status;
	assign result.attributes   = res_q.attributes;

endmodule
